>>> rtl/jsbc_pkg.sv
// ----------------------------------------------------------------------------
// jsbc_pkg
// Shared types, codes and character constants for the JSON structure bound
// checker: reject causes, register indexes, limit bundle and result bundle.
// ----------------------------------------------------------------------------
package jsbc_pkg;

    // Default text capacity; sets the reset value of the length limit
    localparam int unsigned TEXT_CAPACITY_DEF = 4096;

    // Field widths
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned DEPTH_W = 4;
    localparam int unsigned TOK_W   = 8;
    localparam int unsigned ZRUN_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    // Byte count saturates here
    localparam logic [LEN_W-1:0] COUNT_MAX = '1;

    // Reset values of the depth and token limits
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 4'd8;
    localparam logic [TOK_W-1:0]   TOKEN_LIMIT_RST = 8'd96;

    // Zero run value after which a \u0000 escape is complete
    localparam logic [ZRUN_W-1:0] ZRUN_LAST = 3'd4;

    // Characters of interest
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_CTRL_END  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;

    // Reject causes
    typedef enum logic [3:0] {
        CAUSE_NONE     = 4'd0,
        CAUSE_NUL      = 4'd1,
        CAUSE_CTRL     = 4'd2,
        CAUSE_U0000    = 4'd3,
        CAUSE_DEPTH    = 4'd4,
        CAUSE_CLOSE    = 4'd5,
        CAUSE_TOKENS   = 4'd6,
        CAUSE_LENGTH   = 4'd7,
        CAUSE_UNCLOSED = 4'd8
    } cause_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH_LIMIT = 2'd0,
        CFG_DEPTH_LIMIT  = 2'd1,
        CFG_TOKEN_LIMIT  = 2'd2
    } cfg_index_t;

    // Current limits
    typedef struct packed {
        logic [LEN_W-1:0]   length_limit;
        logic [DEPTH_W-1:0] depth_limit;
        logic [TOK_W-1:0]   token_limit;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic   verdict_ready;
        logic   accepted;
        cause_t reject_cause;
    } result_t;

endpackage

>>> rtl/jsbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// jsbc_cfg_regs
// Limit registers of the bound checker, written through a plain write port.
// ----------------------------------------------------------------------------
module jsbc_cfg_regs #(
    parameter int unsigned TEXT_CAPACITY = jsbc_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [jsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jsbc_pkg::CFG_DATA_W-1:0] cfg_write_data,
    output jsbc_pkg::cfg_t                  cfg
);
    import jsbc_pkg::*;

    // Length limit resets to the capacity, clipped to the counter range
    localparam logic [LEN_W-1:0] LENGTH_LIMIT_RST =
        (TEXT_CAPACITY > int'(COUNT_MAX)) ? COUNT_MAX : LEN_W'(TEXT_CAPACITY);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LENGTH_LIMIT: cfg_next.length_limit = cfg_write_data[LEN_W-1:0];
                CFG_DEPTH_LIMIT:  cfg_next.depth_limit  = cfg_write_data[DEPTH_W-1:0];
                CFG_TOKEN_LIMIT:  cfg_next.token_limit  = cfg_write_data[TOK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_limit <= LENGTH_LIMIT_RST;
            cfg_reg.depth_limit  <= DEPTH_LIMIT_RST;
            cfg_reg.token_limit  <= TOKEN_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/jsbc_scan_core.sv
// ----------------------------------------------------------------------------
// jsbc_scan_core
// Per-text scan state and the combinational update for one byte: string and
// escape tracking, \u0000 zero run, nesting depth, token and byte counts, and
// the verdict on the last byte.
// ----------------------------------------------------------------------------
module jsbc_scan_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  jsbc_pkg::cfg_t         cfg,
    output jsbc_pkg::result_t      result
);
    import jsbc_pkg::*;

    logic               inside_string_reg,  inside_string_next;
    logic               escape_pending_reg, escape_pending_next;
    logic [DEPTH_W-1:0] nesting_depth_reg,  nesting_depth_next;
    logic [TOK_W-1:0]   token_count_reg,    token_count_next;
    logic [LEN_W-1:0]   byte_count_reg,     byte_count_next;
    logic [ZRUN_W-1:0]  zero_run_reg,       zero_run_next;
    cause_t             failure_reg,        failure_next;

    logic [TOK_W:0]     token_sum;
    logic               check_tokens;
    logic               is_open;
    logic               is_close;
    logic               is_separator;
    cause_t             verdict_cause;

    assign is_open      = (data_byte == CHAR_LBRACE) || (data_byte == CHAR_LBRACKET);
    assign is_close     = (data_byte == CHAR_RBRACE) || (data_byte == CHAR_RBRACKET);
    assign is_separator = (data_byte == CHAR_COMMA)  || (data_byte == CHAR_COLON);

    // Scan one byte against the current state
    always_comb
    begin
        inside_string_next  = inside_string_reg;
        escape_pending_next = escape_pending_reg;
        nesting_depth_next  = nesting_depth_reg;
        token_count_next    = token_count_reg;
        zero_run_next       = zero_run_reg;
        failure_next        = failure_reg;
        token_sum           = {1'b0, token_count_reg};
        check_tokens        = 1'b0;
        byte_count_next     = (byte_count_reg != COUNT_MAX) ?
                              byte_count_reg + LEN_W'(1) : byte_count_reg;

        if (failure_reg == CAUSE_NONE)
        begin
            if (data_byte == CHAR_NUL)
            begin
                failure_next = CAUSE_NUL;
            end
            else if (inside_string_reg)
            begin
                if ((zero_run_reg != '0) && (data_byte == CHAR_ZERO))
                begin
                    // Count zeros after \u; the fourth one rejects
                    zero_run_next = zero_run_reg + ZRUN_W'(1);
                    if (zero_run_reg >= ZRUN_LAST)
                    begin
                        failure_next = CAUSE_U0000;
                    end
                end
                else
                begin
                    zero_run_next = '0;
                    if (escape_pending_reg)
                    begin
                        if (data_byte == CHAR_LOWER_U)
                        begin
                            zero_run_next = ZRUN_W'(1);
                        end
                        escape_pending_next = 1'b0;
                    end
                    else if (data_byte == CHAR_BACKSLASH)
                    begin
                        escape_pending_next = 1'b1;
                    end
                    else if (data_byte == CHAR_QUOTE)
                    begin
                        inside_string_next = 1'b0;
                    end
                    else if (data_byte < CHAR_CTRL_END)
                    begin
                        failure_next = CAUSE_CTRL;
                    end
                end
            end
            else
            begin
                check_tokens = 1'b1;
                if (data_byte == CHAR_QUOTE)
                begin
                    inside_string_next = 1'b1;
                    token_sum          = {1'b0, token_count_reg} + (TOK_W+1)'(1);
                end
                else if (is_open)
                begin
                    if (({1'b0, nesting_depth_reg} + (DEPTH_W+1)'(1)) >
                        {1'b0, cfg.depth_limit})
                    begin
                        failure_next = CAUSE_DEPTH;
                        check_tokens = 1'b0;
                    end
                    else
                    begin
                        nesting_depth_next = nesting_depth_reg + DEPTH_W'(1);
                        token_sum          = {1'b0, token_count_reg} + (TOK_W+1)'(1);
                    end
                end
                else if (is_close)
                begin
                    if (nesting_depth_reg == '0)
                    begin
                        failure_next = CAUSE_CLOSE;
                        check_tokens = 1'b0;
                    end
                    else
                    begin
                        nesting_depth_next = nesting_depth_reg - DEPTH_W'(1);
                    end
                end
                else if (is_separator)
                begin
                    token_sum = {1'b0, token_count_reg} + (TOK_W+1)'(1);
                end

                if (check_tokens && (token_sum > {1'b0, cfg.token_limit}))
                begin
                    failure_next = CAUSE_TOKENS;
                end
                token_count_next = token_sum[TOK_W-1:0];
            end
        end
    end

    // Pick the verdict: length first, then the first failure, then unclosed
    always_comb
    begin
        if (byte_count_next >= cfg.length_limit)
        begin
            verdict_cause = CAUSE_LENGTH;
        end
        else if (failure_next != CAUSE_NONE)
        begin
            verdict_cause = failure_next;
        end
        else if ((nesting_depth_next != '0) || inside_string_next)
        begin
            verdict_cause = CAUSE_UNCLOSED;
        end
        else
        begin
            verdict_cause = CAUSE_NONE;
        end
    end

    // Drive the result for this byte
    always_comb
    begin
        result.verdict_ready = last_byte;
        result.accepted      = last_byte && (verdict_cause == CAUSE_NONE);
        result.reject_cause  = last_byte ? verdict_cause : CAUSE_NONE;
    end

    // Advance state on a step; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_string_reg  <= 1'b0;
            escape_pending_reg <= 1'b0;
            nesting_depth_reg  <= '0;
            token_count_reg    <= '0;
            byte_count_reg     <= '0;
            zero_run_reg       <= '0;
            failure_reg        <= CAUSE_NONE;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                inside_string_reg  <= 1'b0;
                escape_pending_reg <= 1'b0;
                nesting_depth_reg  <= '0;
                token_count_reg    <= '0;
                byte_count_reg     <= '0;
                zero_run_reg       <= '0;
                failure_reg        <= CAUSE_NONE;
            end
            else
            begin
                inside_string_reg  <= inside_string_next;
                escape_pending_reg <= escape_pending_next;
                nesting_depth_reg  <= nesting_depth_next;
                token_count_reg    <= token_count_next;
                byte_count_reg     <= byte_count_next;
                zero_run_reg       <= zero_run_next;
                failure_reg        <= failure_next;
            end
        end
    end

`ifndef SYNTHESIS
    // State is back to reset after the last byte of a text
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> ((byte_count_reg == '0) && (failure_reg == CAUSE_NONE)
                                 && !inside_string_reg && (nesting_depth_reg == '0)))
        else $error("scan state not cleared after last byte");

    // The first failure cause is kept for the rest of the text
    a_failure_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !last_byte && (failure_reg != CAUSE_NONE)) |=>
            (failure_reg == $past(failure_reg)))
        else $error("failure cause changed within a text");

    // Zero tracking only happens inside a string
    a_zero_run_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        (zero_run_reg != '0) |-> inside_string_reg)
        else $error("zero run active outside a string");
`endif

endmodule

>>> rtl/json_structure_bound_checker_unit.sv
// ----------------------------------------------------------------------------
// json_structure_bound_checker_unit
// Checks a JSON text, one byte per transaction, against length, depth and
// token bounds and reports a verdict on the last byte of each text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall carries data_byte and last_byte.
//   Output channel out_valid / out_stall carries verdict_ready, accepted and
//   reject_cause; exactly one output transaction follows each input one, in
//   order. verdict_ready is high only for the last byte of a text; otherwise
//   accepted and reject_cause are zero.
//   A byte is held in the input register until the scan stage loads its
//   result into the result register, which raises out_valid. Throughput
//   is one byte per cycle while the receiver does not stall, set by the
//   combinational scan update.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; then in_stall rises until the
//   result is taken.
//   The limit registers are written through cfg_write_en / cfg_index /
//   cfg_write_data and should change only while no text is in flight.
//   Reset empties both registers, clears the scan state and loads the
//   default limits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_structure_bound_checker_unit #(
    parameter int unsigned TEXT_CAPACITY = jsbc_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input byte channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    // Result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            verdict_ready,
    output logic                            accepted,
    output logic [3:0]                      reject_cause,
    // Configuration write port
    input  logic                            cfg_write_en,
    input  logic [jsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jsbc_pkg::CFG_DATA_W-1:0] cfg_write_data
);
    import jsbc_pkg::*;

    cfg_t       cfg;
    result_t    scan_result;

    logic       in_valid_reg,  in_valid_next;
    logic [7:0] data_byte_reg;
    logic       last_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg;

    logic       in_take;
    logic       advance;
    logic       out_take;

    jsbc_cfg_regs #(
        .TEXT_CAPACITY (TEXT_CAPACITY)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .cfg            (cfg)
    );

    jsbc_scan_core u_scan_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (data_byte_reg),
        .last_byte (last_byte_reg),
        .cfg       (cfg),
        .result    (scan_result)
    );

    // Handshake: move the held byte into the result register when it is free
    assign out_take = out_valid_reg && !out_stall;
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_byte_reg <= data_byte;
            last_byte_reg <= last_byte;
        end
    end

    // Capture the result transaction
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= scan_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict_ready = result_reg.verdict_ready;
    assign accepted      = result_reg.accepted;
    assign reject_cause  = result_reg.reject_cause;

`ifndef SYNTHESIS
    // A shown result without a verdict carries no cause and no pass
    a_no_verdict_no_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.verdict_ready) |->
            (!result_reg.accepted && (result_reg.reject_cause == CAUSE_NONE)))
        else $error("verdict fields set without verdict_ready");

    // A pass never carries a cause
    a_accept_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.accepted) |->
            (result_reg.verdict_ready && (result_reg.reject_cause == CAUSE_NONE)))
        else $error("accepted text reports a reject cause");

    // A scanned byte always appears as a result in the next cycle
    a_advance_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("scanned byte produced no result");
`endif

endmodule

>>> bench/json_structure_bound_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// json_structure_bound_checker_unit_tb
// Streams JSON texts byte by byte into the bound checker and compares every
// result transaction against a cycle-free predictor of the scan state. Runs
// directed corner texts, filler texts and random well-formed, broken and
// noise texts under several limit settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module json_structure_bound_checker_unit_tb;

    import jsbc_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_AT_RESULT  = 150;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAFT_SOFT_CAP  = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int FILLER_LENGTH   = 60;

    typedef struct packed {
        logic [7:0] value;
        logic       is_final;
    } text_byte_t;

    // Clock, reset and block inputs
    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic [7:0]            data_byte      = 8'h00;
    logic                  last_byte      = 1'b0;
    logic                  out_stall      = 1'b0;
    logic                  cfg_write_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_write_data = '0;

    // Block outputs
    logic       in_stall;
    logic       out_valid;
    logic       verdict_ready;
    logic       accepted;
    logic [3:0] reject_cause;

    // Limits as the predictor sees them
    logic [LEN_W-1:0]   max_length = LEN_W'(TEXT_CAPACITY_DEF);
    logic [DEPTH_W-1:0] max_depth  = DEPTH_LIMIT_RST;
    logic [TOK_W-1:0]   max_tokens = TOKEN_LIMIT_RST;

    // Scan state of the predictor
    logic               in_quotes    = 1'b0;
    logic               escape_armed = 1'b0;
    logic [DEPTH_W-1:0] open_depth   = '0;
    logic [TOK_W-1:0]   token_tally  = '0;
    logic [LEN_W-1:0]   text_length  = '0;
    logic [ZRUN_W-1:0]  zero_streak  = '0;
    cause_t             first_fault  = CAUSE_NONE;

    // Traffic between the stimulus, the driver and the monitor
    text_byte_t  byte_backlog[$];
    result_t     verdict_queue[$];
    logic [7:0]  draft[$];
    text_byte_t  outgoing;
    result_t     wanted;
    int          send_gap       = 0;
    int          stall_left     = 0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned texts_queued    = 0;
    int unsigned texts_clean     = 0;
    int unsigned bytes_queued    = 0;
    int unsigned settings_used   = 1;

    json_structure_bound_checker_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict_ready  (verdict_ready),
        .accepted       (accepted),
        .reject_cause   (reject_cause),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Pick an idle length: mostly none or short, a few long, none in calm stretches
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if ((($time / (CLK_PERIOD * 300)) % 2) == 1)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Advance the structure scan by one byte of a text that has not failed yet
    function automatic void scan_structure(input logic [7:0] ch);
        logic [TOK_W:0] tally;
        if (ch == CHAR_NUL)
        begin
            first_fault = CAUSE_NUL;
            return;
        end
        if (in_quotes)
        begin
            if (zero_streak != '0)
            begin
                if (ch == CHAR_ZERO)
                begin
                    zero_streak = zero_streak + ZRUN_W'(1);
                    if (zero_streak > ZRUN_LAST)
                        first_fault = CAUSE_U0000;
                    return;
                end
                zero_streak = '0;
            end
            if (escape_armed)
            begin
                if (ch == CHAR_LOWER_U)
                    zero_streak = ZRUN_W'(1);
                escape_armed = 1'b0;
            end
            else if (ch == CHAR_BACKSLASH)
                escape_armed = 1'b1;
            else if (ch == CHAR_QUOTE)
                in_quotes = 1'b0;
            else if (ch < CHAR_CTRL_END)
                first_fault = CAUSE_CTRL;
            return;
        end
        tally = {1'b0, token_tally};
        if (ch == CHAR_QUOTE)
        begin
            in_quotes = 1'b1;
            tally = tally + (TOK_W+1)'(1);
        end
        else if (ch == CHAR_LBRACE || ch == CHAR_LBRACKET)
        begin
            if (({1'b0, open_depth} + (DEPTH_W+1)'(1)) > {1'b0, max_depth})
            begin
                first_fault = CAUSE_DEPTH;
                return;
            end
            open_depth = open_depth + DEPTH_W'(1);
            tally = tally + (TOK_W+1)'(1);
        end
        else if (ch == CHAR_RBRACE || ch == CHAR_RBRACKET)
        begin
            if (open_depth == '0)
            begin
                first_fault = CAUSE_CLOSE;
                return;
            end
            open_depth = open_depth - DEPTH_W'(1);
        end
        else if (ch == CHAR_COMMA || ch == CHAR_COLON)
            tally = tally + (TOK_W+1)'(1);
        if (tally > {1'b0, max_tokens})
            first_fault = CAUSE_TOKENS;
        token_tally = tally[TOK_W-1:0];
    endfunction

    // Work out the result of one byte; give the verdict and clear on the last byte
    function automatic result_t judge_byte(input logic [7:0] ch, input logic is_final);
        result_t verdict;
        cause_t  cause;
        verdict = '0;
        if (text_length != COUNT_MAX)
            text_length = text_length + LEN_W'(1);
        if (first_fault == CAUSE_NONE)
            scan_structure(ch);
        if (is_final)
        begin
            if (text_length >= max_length)
                cause = CAUSE_LENGTH;
            else if (first_fault != CAUSE_NONE)
                cause = first_fault;
            else if (open_depth != '0 || in_quotes)
                cause = CAUSE_UNCLOSED;
            else
                cause = CAUSE_NONE;
            verdict.verdict_ready = 1'b1;
            verdict.accepted      = (cause == CAUSE_NONE);
            verdict.reject_cause  = cause;
            in_quotes    = 1'b0;
            escape_armed = 1'b0;
            open_depth   = '0;
            token_tally  = '0;
            text_length  = '0;
            zero_streak  = '0;
            first_fault  = CAUSE_NONE;
        end
        return verdict;
    endfunction

    // Send bytes from the backlog, holding a stalled transaction unchanged
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
            send_gap  = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (byte_backlog.size() != 0)
            begin
                outgoing = byte_backlog.pop_front();
                in_valid  <= 1'b1;
                data_byte <= outgoing.value;
                last_byte <= outgoing.is_final;
                send_gap  = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Check each result transaction and drive the receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("result transaction with no verdict pending");
                    mismatch_count++;
                end
                else
                begin
                    wanted = verdict_queue.pop_front();
                    if (verdict_ready !== wanted.verdict_ready)
                    begin
                        $error("verdict_ready: expected %0d, got %0d",
                               wanted.verdict_ready, verdict_ready);
                        mismatch_count++;
                    end
                    if (accepted !== wanted.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d", wanted.accepted, accepted);
                        mismatch_count++;
                    end
                    if (reject_cause !== wanted.reject_cause)
                    begin
                        $error("reject_cause: expected %0d, got %0d",
                               wanted.reject_cause, reject_cause);
                        mismatch_count++;
                    end
                end
                results_checked++;
                // hold off once for a long stretch so the block backs up
                if (results_checked == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // End the run if nothing moves for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic put_byte(input logic [7:0] ch);
        draft.push_back(ch);
    endtask

    // Predict the draft text and hand it to the driver
    task automatic queue_draft();
        result_t    verdict;
        text_byte_t item;
        verdict = '0;
        @(negedge clk);
        foreach (draft[i])
        begin
            item.value    = draft[i];
            item.is_final = (i == draft.size() - 1);
            verdict = judge_byte(item.value, item.is_final);
            verdict_queue.push_back(verdict);
            byte_backlog.push_back(item);
        end
        texts_queued++;
        bytes_queued += draft.size();
        if (verdict.accepted)
            texts_clean++;
    endtask

    task automatic queue_string(input string text);
        draft.delete();
        for (int i = 0; i < text.len(); i++)
            put_byte(text[i]);
        queue_draft();
    endtask

    // Wait until every verdict has come back, then let the pipeline settle
    task automatic drain();
        while (byte_backlog.size() != 0 || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_LENGTH_LIMIT: max_length = value;
            CFG_DEPTH_LIMIT:  max_depth  = value[DEPTH_W-1:0];
            CFG_TOKEN_LIMIT:  max_tokens = value[TOK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] length_value,
                              input logic [CFG_DATA_W-1:0] depth_value,
                              input logic [CFG_DATA_W-1:0] token_value);
        drain();
        write_limit(CFG_LENGTH_LIMIT, length_value);
        write_limit(CFG_DEPTH_LIMIT, depth_value);
        write_limit(CFG_TOKEN_LIMIT, token_value);
        settings_used++;
    endtask

    // Build a string with plain, high, control and escaped characters
    task automatic compose_string();
        int         roll;
        int         zeros;
        logic [7:0] ch;
        put_byte(CHAR_QUOTE);
        repeat ($urandom_range(0, 6))
        begin
            roll = $urandom_range(0, 19);
            if (roll < 12)
            begin
                ch = 8'($urandom_range(8'h20, 8'h7E));
                if (ch == CHAR_QUOTE || ch == CHAR_BACKSLASH)
                    ch = "x";
                put_byte(ch);
            end
            else if (roll < 14)
                put_byte(8'($urandom_range(8'h80, 8'hFF)));
            else if (roll < 16)
            begin
                put_byte(CHAR_BACKSLASH);
                put_byte(roll == 14 ? CHAR_QUOTE : CHAR_BACKSLASH);
            end
            else if (roll < 18)
            begin
                // unicode escape with a random number of leading zeros
                put_byte(CHAR_BACKSLASH);
                put_byte(CHAR_LOWER_U);
                zeros = $urandom_range(0, 4);
                repeat (zeros) put_byte(CHAR_ZERO);
                if (zeros < 4)
                    put_byte(8'($urandom_range(8'h31, 8'h39)));
            end
            else if (roll < 19)
                put_byte(8'($urandom_range(1, 8'h1F)));
            else
            begin
                put_byte(CHAR_BACKSLASH);
                put_byte(8'($urandom_range(1, 255)));
            end
        end
        put_byte(CHAR_QUOTE);
    endtask

    // Build a JSON value nested at most the given number of levels
    task automatic compose_value(input int levels);
        int roll;
        int members;
        int m;
        roll = $urandom_range(0, 9);
        if (levels > 0 && draft.size() < DRAFT_SOFT_CAP && roll < 4)
        begin
            members = $urandom_range(0, 3);
            put_byte(roll < 2 ? CHAR_LBRACE : CHAR_LBRACKET);
            for (m = 0; m < members; m++)
            begin
                if (m != 0)
                    put_byte(CHAR_COMMA);
                if ($urandom_range(0, 3) == 0)
                    put_byte(8'h20);
                if (roll < 2)
                begin
                    compose_string();
                    put_byte(CHAR_COLON);
                end
                compose_value(levels - 1);
            end
            put_byte(roll < 2 ? CHAR_RBRACE : CHAR_RBRACKET);
        end
        else if (roll < 7)
            compose_string();
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) == 0)
                    put_byte(8'($urandom_range(8'h30, 8'h39)));
                else
                    put_byte(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
    endtask

    // Mostly well-formed texts, some broken ones, some deep chains and noise
    task automatic queue_random_text();
        int mode;
        int depth_run;
        mode = $urandom_range(0, 19);
        draft.delete();
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
        end
        else if (mode == 1)
        begin
            depth_run = $urandom_range(1, 17);
            repeat (depth_run) put_byte($urandom_range(0, 1) ? CHAR_LBRACE : CHAR_LBRACKET);
            repeat (depth_run) put_byte($urandom_range(0, 1) ? CHAR_RBRACE : CHAR_RBRACKET);
        end
        else
        begin
            compose_value($urandom_range(0, 5));
            case (mode)
                2: draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
                3: if (draft.size() > 1) void'(draft.pop_back());
                4: draft.push_back(CHAR_RBRACKET);
                5: draft.push_front(CHAR_RBRACE);
                default: ;
            endcase
        end
        queue_draft();
    endtask

    task automatic run_random(input int byte_quota);
        int unsigned start_bytes;
        start_bytes = bytes_queued;
        while (bytes_queued - start_bytes < byte_quota)
            queue_random_text();
    endtask

    // Filler text of a given length, optionally opened by a stray close
    task automatic queue_long_text(input int length, input logic stray_close);
        draft.delete();
        put_byte(stray_close ? CHAR_RBRACKET : CHAR_LBRACKET);
        repeat (length - 2) put_byte($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(8'h30, 8'h39)));
        put_byte(CHAR_RBRACKET);
        queue_draft();
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed texts under the reset limits
        queue_string("{}");
        queue_string("[{\"k\":[1,2]}]");
        queue_string("\"\\u0000\"");
        queue_string("\"\\u000a\"");
        queue_string("\"\\\\\"");
        queue_string("]");
        queue_string("[\"");
        draft.delete();
        put_byte(CHAR_NUL);
        queue_draft();
        draft.delete();
        put_byte(CHAR_QUOTE);
        put_byte(8'h01);
        put_byte(CHAR_QUOTE);
        queue_draft();
        draft.delete();
        put_byte(CHAR_QUOTE);
        put_byte(8'hFF);
        put_byte(CHAR_QUOTE);
        queue_draft();

        // filler texts, one of them opened by a stray close
        queue_long_text(FILLER_LENGTH, 1'b0);
        queue_long_text(FILLER_LENGTH, 1'b1);
        run_random(160);

        // tight limits to reach depth, token and length rejections directly
        set_limits(13'd12, 13'd2, 13'd3);
        queue_string("[[[");
        queue_string(",,,,");
        queue_string("[[]]");
        queue_string("\"abcdefghi\"");
        queue_string("\"abcdefghij\"");
        run_random(120);

        // widest depth and token limits, length limit at the default capacity
        set_limits(13'd4096, 13'd15, 13'd255);
        run_random(160);

        // all limits at one: every text is too long
        set_limits(13'd1, 13'd1, 13'd1);
        run_random(40);

        set_limits(13'($urandom_range(10, 60)), 13'($urandom_range(1, 4)),
                   13'($urandom_range(1, 12)));
        run_random(160);

        set_limits(13'($urandom_range(200, 4096)), 13'($urandom_range(2, 15)),
                   13'($urandom_range(8, 255)));
        run_random(160);

        drain();
        $display("covered %0d texts (%0d expected to pass), %0d bytes, %0d limit settings",
                 texts_queued, texts_clean, bytes_queued, settings_used);
        $display("checked %0d result transactions, %0d field mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
